### hw/rtl/tpwd_pkg.sv
// Shared widths, constants, register indexes and control types for the turn drive block
`timescale 1ns / 1ps
`default_nettype none

package tpwd_pkg;

    // field and datapath widths
    localparam int HEADING_W  = 18;
    localparam int SPEED_W    = 22;
    localparam int TSPEED_W   = 21;
    localparam int SIDES_W    = 2;
    localparam int DRIVE_W    = 8;
    localparam int ERR_W      = 19;
    localparam int NUM_W      = 28;
    localparam int MAG_W      = 27;
    localparam int REM_W      = 20;
    localparam int ACC_W      = 35;
    localparam int DIGIT_W    = 13;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 21;

    // default speed format
    localparam int DEF_SPEED_FRACTION_BITS = 20;

    // turn law: (22*e + 220*d) * 2^F / 10^6, rounded half away from zero
    localparam int K_P_NUM    = 22;
    localparam int K_D_NUM    = 220;
    localparam int DIVISOR    = 1000000;
    localparam int ROUND_HALF = 500000;

    // wheel law: 1700*t + 1000*(t - p) + 500*(t - m) = 3200*t - 1000*p - 500*m
    localparam int K_TARGET = 3200;
    localparam int K_PREV   = 1000;
    localparam int K_MEAS   = 500;

    // one degree band and drive saturation
    localparam int AT_BAND     = 100;
    localparam int DRIVE_LIMIT = 127;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_HEADING = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_TURN_SPEED = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_TURN_SPEED = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TURN_SIDES     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_REVERSE_MODE   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_OVERRIDE_LEFT  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_OVERRIDE_RIGHT = 3'd6;

    // sequencer to divider
    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

    // sequencer to wheel lanes
    typedef struct packed {
        logic load;
        logic step;
        logic msb;
    } lane_ctrl_t;

    // one bit-slice of the wheel sum: weights of the target, previous target and measured bits
    function automatic logic signed [DIGIT_W-1:0] drive_digit(
        input logic bit_t,
        input logic bit_p,
        input logic bit_m
    );
        logic signed [DIGIT_W-1:0] d;
        d = '0;
        if (bit_t) begin
            d = d + DIGIT_W'(K_TARGET);
        end
        if (bit_p) begin
            d = d - DIGIT_W'(K_PREV);
        end
        if (bit_m) begin
            d = d - DIGIT_W'(K_MEAS);
        end
        return d;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/tpwd_div.sv
// Bit-serial restoring divider by the constant turn-law divisor
`timescale 1ns / 1ps
`default_nettype none

module tpwd_div #(
    parameter int DVD_W = tpwd_pkg::MAG_W + tpwd_pkg::DEF_SPEED_FRACTION_BITS + 1
) (
    input  wire logic                   aclk,
    input  wire tpwd_pkg::div_ctrl_t    ctrl,
    input  wire logic [DVD_W-1:0]       dividend,
    output logic      [DVD_W-1:0]       quotient
);

    localparam int TRIAL_W = tpwd_pkg::REM_W + 1;

    logic [DVD_W-1:0]              dvd_reg;
    logic [DVD_W-1:0]              quo_reg;
    logic [tpwd_pkg::REM_W-1:0]    rem_reg;
    logic [TRIAL_W-1:0]            trial;
    logic [TRIAL_W-1:0]            diff;
    logic                          ge;
    logic [tpwd_pkg::REM_W-1:0]    rem_next;

    // one quotient bit per cycle while step is high, dividend msb first
    always_comb begin
        trial    = {rem_reg, dvd_reg[DVD_W-1]};
        ge       = (trial >= TRIAL_W'(tpwd_pkg::DIVISOR));
        diff     = trial - TRIAL_W'(tpwd_pkg::DIVISOR);
        rem_next = ge ? diff[tpwd_pkg::REM_W-1:0] : trial[tpwd_pkg::REM_W-1:0];
    end

    // shift registers
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (ctrl.step) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
        end
    end

    assign quotient = quo_reg;

endmodule

`default_nettype wire

### hw/rtl/tpwd_lane.sv
// Bit-serial wheel lane: feedforward plus speed feedback sum, scaling and saturation
`timescale 1ns / 1ps
`default_nettype none

module tpwd_lane #(
    parameter int SPEED_FRACTION_BITS = tpwd_pkg::DEF_SPEED_FRACTION_BITS
) (
    input  wire logic                                 aclk,
    input  wire tpwd_pkg::lane_ctrl_t                 ctrl,
    input  wire logic signed [tpwd_pkg::SPEED_W-1:0]  target,
    input  wire logic signed [tpwd_pkg::SPEED_W-1:0]  prev,
    input  wire logic signed [tpwd_pkg::SPEED_W-1:0]  meas,
    output logic signed      [tpwd_pkg::DRIVE_W-1:0]  drive
);

    localparam int SW = tpwd_pkg::SPEED_W;
    localparam int AW = tpwd_pkg::ACC_W;
    localparam int DW = tpwd_pkg::DRIVE_W;

    logic [SW-1:0]                        tgt_sh_reg;
    logic [SW-1:0]                        prev_sh_reg;
    logic [SW-1:0]                        meas_sh_reg;
    logic signed [AW-1:0]                 acc_reg;
    logic signed [AW-1:0]                 acc_next;
    logic signed [tpwd_pkg::DIGIT_W-1:0]  digit;
    logic                                 neg;
    logic [AW-1:0]                        acc_mag;
    logic [AW-1:0]                        scaled;
    logic [DW-1:0]                        sat_mag;

    // horner step over the operand bits, msb carries negative weight
    always_comb begin
        digit = tpwd_pkg::drive_digit(tgt_sh_reg[SW-1], prev_sh_reg[SW-1], meas_sh_reg[SW-1]);
        if (ctrl.msb) begin
            acc_next = -AW'(digit);
        end else begin
            acc_next = (acc_reg <<< 1) + AW'(digit);
        end
    end

    // operand shift registers and accumulator
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            tgt_sh_reg  <= target;
            prev_sh_reg <= prev;
            meas_sh_reg <= meas;
            acc_reg     <= '0;
        end else if (ctrl.step) begin
            tgt_sh_reg  <= {tgt_sh_reg[SW-2:0], 1'b0};
            prev_sh_reg <= {prev_sh_reg[SW-2:0], 1'b0};
            meas_sh_reg <= {meas_sh_reg[SW-2:0], 1'b0};
            acc_reg     <= acc_next;
        end
    end

    // drop fraction toward zero, then saturate
    always_comb begin
        neg     = acc_reg[AW-1];
        acc_mag = neg ? AW'(-acc_reg) : AW'(acc_reg);
        scaled  = acc_mag >> SPEED_FRACTION_BITS;
        if (scaled > AW'(tpwd_pkg::DRIVE_LIMIT)) begin
            sat_mag = DW'(tpwd_pkg::DRIVE_LIMIT);
        end else begin
            sat_mag = scaled[DW-1:0];
        end
        drive = neg ? -$signed(sat_mag) : $signed(sat_mag);
    end

endmodule

`default_nettype wire

### hw/rtl/turn_pd_wheel_drive_top.sv
// Heading PD turn controller with per-wheel feedforward drive, top level
//
// One input transaction (heading, left and right wheel speed) gives one result
// transaction (left drive, right drive, at_target). Both channels use valid/ready.
// Configuration registers are written through cfg_wr_en / cfg_addr / cfg_wdata,
// taken at once, and must only change while the block is idle.
//
// Timing: one transaction at a time. The result is registered once the sequencer
// has gone through its NUM, LOAD, DIV, CLAMP, DRV and OUT states, and the block
// then returns to idle to take the next input. The work is done by the bit-serial
// divider (one quotient bit per cycle over the 28 + SPEED_FRACTION_BITS bit
// dividend) followed by the bit-serial wheel lanes over the 22-bit speeds, which
// run side by side.
//
// Reset (aresetn low, synchronous) clears the previous error and wheel targets,
// sets turn_sides to 3 and all other configuration registers to 0, and empties the output.
// A result waiting on a stalled receiver sits in the output register; the next
// input is still accepted and worked on, and only the final load waits for it.
`timescale 1ns / 1ps
`default_nettype none

module turn_pd_wheel_drive_top #(
    parameter int SPEED_FRACTION_BITS = tpwd_pkg::DEF_SPEED_FRACTION_BITS
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    // configuration
    input  wire logic                                    cfg_wr_en,
    input  wire logic [tpwd_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  wire logic [tpwd_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    // input channel
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic signed [tpwd_pkg::HEADING_W-1:0]   s_heading,
    input  wire logic signed [tpwd_pkg::SPEED_W-1:0]     s_left_speed,
    input  wire logic signed [tpwd_pkg::SPEED_W-1:0]     s_right_speed,
    // result channel
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic signed [tpwd_pkg::DRIVE_W-1:0]          m_left_drive,
    output logic signed [tpwd_pkg::DRIVE_W-1:0]          m_right_drive,
    output logic                                         m_at_target
);

    localparam int DVD_W = tpwd_pkg::MAG_W + SPEED_FRACTION_BITS + 1;
    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam int HW    = tpwd_pkg::HEADING_W;
    localparam int SW    = tpwd_pkg::SPEED_W;
    localparam int TW    = tpwd_pkg::TSPEED_W;
    localparam int EW    = tpwd_pkg::ERR_W;
    localparam int NW    = tpwd_pkg::NUM_W;
    localparam int DW    = tpwd_pkg::DRIVE_W;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_NUM   = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_CLAMP = 3'd4;
    localparam logic [2:0] ST_DRV   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    // sequencer
    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_load;
    tpwd_pkg::div_ctrl_t   div_ctrl;
    tpwd_pkg::lane_ctrl_t  lane_ctrl;

    // configuration registers
    logic signed [HW-1:0]               tgt_heading_reg;
    logic [TW-1:0]                      max_speed_reg;
    logic [TW-1:0]                      min_speed_reg;
    logic [tpwd_pkg::SIDES_W-1:0]       sides_reg;
    logic                               reverse_reg;
    logic signed [DW-1:0]               ovr_left_reg;
    logic signed [DW-1:0]               ovr_right_reg;

    // controller state
    logic signed [EW-1:0]  last_error_reg;
    logic signed [SW-1:0]  last_left_reg;
    logic signed [SW-1:0]  last_right_reg;
    logic                  at_reg;

    // per-transaction work registers
    logic signed [EW-1:0]  err_reg;
    logic signed [SW-1:0]  ls_reg;
    logic signed [SW-1:0]  rs_reg;
    logic signed [NW-1:0]  num_reg;
    logic                  neg_reg;

    // output register
    logic                  m_valid_reg;
    logic signed [DW-1:0]  m_left_reg;
    logic signed [DW-1:0]  m_right_reg;
    logic                  m_at_reg;

    // datapath nets
    logic signed [EW-1:0]  err_in;
    logic signed [NW-1:0]  err_x;
    logic signed [NW-1:0]  der_x;
    logic signed [NW-1:0]  num_next;
    logic signed [NW-1:0]  num_abs;
    logic [tpwd_pkg::MAG_W-1:0] num_mag;
    logic [DVD_W-1:0]      dividend;
    logic [DVD_W-1:0]      quotient;
    logic                  q_gt_max;
    logic                  q_lt_min;
    logic [TW-1:0]         turn_mag;
    logic signed [SW-1:0]  turn_out;
    logic                  at_next;
    logic signed [SW-1:0]  tl_next;
    logic signed [SW-1:0]  tr_next;
    logic signed [SW-1:0]  meas_left;
    logic signed [SW-1:0]  meas_right;
    logic signed [DW-1:0]  lane_l_drive;
    logic signed [DW-1:0]  lane_r_drive;
    logic signed [DW-1:0]  drive_l_next;
    logic signed [DW-1:0]  drive_r_next;
    logic                  ovr_active;

    // clamp an override value to the drive limit
    function automatic logic signed [DW-1:0] sat_override(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] r;
        r = v;
        if (v > DW'(tpwd_pkg::DRIVE_LIMIT)) begin
            r = DW'(tpwd_pkg::DRIVE_LIMIT);
        end else if (v < -DW'(tpwd_pkg::DRIVE_LIMIT)) begin
            r = -DW'(tpwd_pkg::DRIVE_LIMIT);
        end
        return r;
    endfunction

    // heading error and pd numerator
    always_comb begin
        err_in   = EW'(tgt_heading_reg) - EW'(s_heading);
        err_x    = NW'(err_reg);
        der_x    = err_x - NW'(last_error_reg);
        num_next = NW'(err_x * tpwd_pkg::K_P_NUM + der_x * tpwd_pkg::K_D_NUM);
        num_abs  = num_reg[NW-1] ? -num_reg : num_reg;
        num_mag  = num_abs[tpwd_pkg::MAG_W-1:0];
        dividend = (DVD_W'(num_mag) << SPEED_FRACTION_BITS) + DVD_W'(tpwd_pkg::ROUND_HALF);
    end

    // magnitude clamp, band test and wheel targets
    always_comb begin
        q_gt_max = (quotient > DVD_W'(max_speed_reg));
        q_lt_min = (quotient < DVD_W'(min_speed_reg));
        if (q_gt_max) begin
            turn_mag = max_speed_reg;
        end else if (q_lt_min) begin
            turn_mag = min_speed_reg;
        end else begin
            turn_mag = quotient[TW-1:0];
        end
        turn_out = neg_reg ? -$signed({1'b0, turn_mag}) : $signed({1'b0, turn_mag});
        at_next  = (err_reg <= EW'(tpwd_pkg::AT_BAND)) && (err_reg >= -EW'(tpwd_pkg::AT_BAND));
        tl_next  = (!at_next && sides_reg[0]) ? turn_out : '0;
        tr_next  = (!at_next && sides_reg[1]) ? -turn_out : '0;
    end

    // reverse mode swaps the measured wheels
    assign meas_left  = reverse_reg ? rs_reg : ls_reg;
    assign meas_right = reverse_reg ? ls_reg : rs_reg;

    // bit-serial divider for the turn speed
    tpwd_div #(
        .DVD_W (DVD_W)
    ) u_div (
        .aclk     (aclk),
        .ctrl     (div_ctrl),
        .dividend (dividend),
        .quotient (quotient)
    );

    // left and right wheel lanes
    tpwd_lane #(
        .SPEED_FRACTION_BITS (SPEED_FRACTION_BITS)
    ) u_lane_l (
        .aclk   (aclk),
        .ctrl   (lane_ctrl),
        .target (tl_next),
        .prev   (last_left_reg),
        .meas   (meas_left),
        .drive  (lane_l_drive)
    );

    tpwd_lane #(
        .SPEED_FRACTION_BITS (SPEED_FRACTION_BITS)
    ) u_lane_r (
        .aclk   (aclk),
        .ctrl   (lane_ctrl),
        .target (tr_next),
        .prev   (last_right_reg),
        .meas   (meas_right),
        .drive  (lane_r_drive)
    );

    // output selection: reverse swap, then override
    always_comb begin
        ovr_active = (ovr_left_reg != '0) || (ovr_right_reg != '0);
        if (ovr_active) begin
            drive_l_next = sat_override(ovr_left_reg);
            drive_r_next = sat_override(ovr_right_reg);
        end else if (reverse_reg) begin
            drive_l_next = lane_r_drive;
            drive_r_next = lane_l_drive;
        end else begin
            drive_l_next = lane_l_drive;
            drive_r_next = lane_r_drive;
        end
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        out_load   = 1'b0;
        div_ctrl   = '0;
        lane_ctrl  = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_NUM;
                end
            end
            ST_NUM: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                div_ctrl.load = 1'b1;
                cnt_next      = '0;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                div_ctrl.step = 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_CLAMP;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_CLAMP: begin
                lane_ctrl.load = 1'b1;
                cnt_next       = '0;
                state_next     = ST_DRV;
            end
            ST_DRV: begin
                lane_ctrl.step = 1'b1;
                lane_ctrl.msb  = (cnt_reg == '0);
                if (cnt_reg == CNT_W'(SW - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_OUT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    // control, configuration and controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
            tgt_heading_reg <= '0;
            max_speed_reg   <= '0;
            min_speed_reg   <= '0;
            sides_reg       <= '1;
            reverse_reg     <= 1'b0;
            ovr_left_reg    <= '0;
            ovr_right_reg   <= '0;
            last_error_reg  <= '0;
            last_left_reg   <= '0;
            last_right_reg  <= '0;
            at_reg          <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    tpwd_pkg::REG_TARGET_HEADING: tgt_heading_reg <= cfg_wdata[HW-1:0];
                    tpwd_pkg::REG_MAX_TURN_SPEED: max_speed_reg   <= cfg_wdata[TW-1:0];
                    tpwd_pkg::REG_MIN_TURN_SPEED: min_speed_reg   <= cfg_wdata[TW-1:0];
                    tpwd_pkg::REG_TURN_SIDES:     sides_reg       <= cfg_wdata[tpwd_pkg::SIDES_W-1:0];
                    tpwd_pkg::REG_REVERSE_MODE:   reverse_reg     <= cfg_wdata[0];
                    tpwd_pkg::REG_OVERRIDE_LEFT:  ovr_left_reg    <= cfg_wdata[DW-1:0];
                    tpwd_pkg::REG_OVERRIDE_RIGHT: ovr_right_reg   <= cfg_wdata[DW-1:0];
                    default: begin
                    end
                endcase
            end
            // lanes pick up the old previous targets on this same edge
            if (state_reg == ST_CLAMP) begin
                last_error_reg <= err_reg;
                last_left_reg  <= tl_next;
                last_right_reg <= tr_next;
                at_reg         <= at_next;
            end
        end
    end

    // work and output payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            err_reg <= err_in;
            ls_reg  <= s_left_speed;
            rs_reg  <= s_right_speed;
        end
        if (state_reg == ST_NUM) begin
            num_reg <= num_next;
        end
        if (state_reg == ST_LOAD) begin
            neg_reg <= num_reg[NW-1];
        end
        if (out_load) begin
            m_left_reg  <= drive_l_next;
            m_right_reg <= drive_r_next;
            m_at_reg    <= at_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_left_drive  = m_left_reg;
    assign m_right_drive = m_right_reg;
    assign m_at_target   = m_at_reg;

    // a new result only comes out of the final state
    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output state");

    // inside the band both stored wheel targets are zero
    a_band_zero_targets: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLAMP && at_next) |=> (last_left_reg == '0 && last_right_reg == '0))
        else $error("wheel targets not cleared inside the heading band");

    // the sign bit step of the lanes follows the lane load
    a_lane_msb_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRV && cnt_reg == '0) |-> $past(state_reg == ST_CLAMP))
        else $error("lane sign step not right after lane load");

    // divider runs exactly its bit count before the clamp
    a_div_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLAMP) |-> $past(state_reg == ST_DIV && cnt_reg == CNT_W'(DVD_W - 1)))
        else $error("clamp entered before the divider finished");

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking testbench for the heading PD turn controller with wheel feedforward drive
`timescale 1ns / 1ps

module testbench;

    // widths and register indexes of the block
    localparam int HEADING_W  = tpwd_pkg::HEADING_W;
    localparam int SPEED_W    = tpwd_pkg::SPEED_W;
    localparam int TSPEED_W   = tpwd_pkg::TSPEED_W;
    localparam int SIDES_W    = tpwd_pkg::SIDES_W;
    localparam int DRIVE_W    = tpwd_pkg::DRIVE_W;
    localparam int CFG_ADDR_W = tpwd_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W = tpwd_pkg::CFG_DATA_W;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_HEADING = tpwd_pkg::REG_TARGET_HEADING;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_TURN_SPEED = tpwd_pkg::REG_MAX_TURN_SPEED;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_TURN_SPEED = tpwd_pkg::REG_MIN_TURN_SPEED;
    localparam logic [CFG_ADDR_W-1:0] REG_TURN_SIDES     = tpwd_pkg::REG_TURN_SIDES;
    localparam logic [CFG_ADDR_W-1:0] REG_REVERSE_MODE   = tpwd_pkg::REG_REVERSE_MODE;
    localparam logic [CFG_ADDR_W-1:0] REG_OVERRIDE_LEFT  = tpwd_pkg::REG_OVERRIDE_LEFT;
    localparam logic [CFG_ADDR_W-1:0] REG_OVERRIDE_RIGHT = tpwd_pkg::REG_OVERRIDE_RIGHT;

    // turn law and wheel law of the block, kept independent of the RTL
    localparam int     FRAC_BITS     = tpwd_pkg::DEF_SPEED_FRACTION_BITS;
    localparam longint TURN_P_GAIN   = 22;
    localparam longint TURN_D_GAIN   = 220;
    localparam longint TURN_SCALE    = 1000000;
    localparam longint WHEEL_KV      = 1700;
    localparam longint WHEEL_KA      = 1000;
    localparam longint WHEEL_KP      = 500;
    localparam longint BAND_HUNDREDS = 100;
    localparam longint DRIVE_MAX     = 127;
    localparam int     SETTLE_CYCLES = FRAC_BITS + 80;

    // field extremes
    localparam int SPEED_TOP    = (1 << (SPEED_W - 1)) - 1;
    localparam int SPEED_BOTTOM = -(1 << (SPEED_W - 1));
    localparam int HEADING_TOP    = (1 << (HEADING_W - 1)) - 1;
    localparam int HEADING_BOTTOM = -(1 << (HEADING_W - 1));

    typedef struct packed {
        logic signed [DRIVE_W-1:0] left_drive;
        logic signed [DRIVE_W-1:0] right_drive;
        logic                      at_target;
    } drive_cmd_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic                          cfg_wr_en;
    logic [CFG_ADDR_W-1:0]         cfg_addr;
    logic [CFG_DATA_W-1:0]         cfg_wdata;
    logic                          s_valid;
    wire                           s_ready;
    logic signed [HEADING_W-1:0]   s_heading;
    logic signed [SPEED_W-1:0]     s_left_speed;
    logic signed [SPEED_W-1:0]     s_right_speed;
    wire                           m_valid;
    logic                          m_ready = 1'b0;
    wire signed [DRIVE_W-1:0]      m_left_drive;
    wire signed [DRIVE_W-1:0]      m_right_drive;
    wire                           m_at_target;

    // register copies, reset values of the block
    logic signed [HEADING_W-1:0] cur_target    = '0;
    logic [TSPEED_W-1:0]         cur_max_speed = '0;
    logic [TSPEED_W-1:0]         cur_min_speed = '0;
    logic [SIDES_W-1:0]          cur_sides     = 2'd3;
    logic                        cur_reverse   = 1'b0;
    logic signed [DRIVE_W-1:0]   cur_ovr_left  = '0;
    logic signed [DRIVE_W-1:0]   cur_ovr_right = '0;

    // controller memory
    longint prev_error        = 0;
    longint prev_left_target  = 0;
    longint prev_right_target = 0;

    drive_cmd_t  pending_cmds[$];
    int unsigned fail_count  = 0;
    bit          steady_flow = 1'b0;

    turn_pd_wheel_drive_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_heading     (s_heading),
        .s_left_speed  (s_left_speed),
        .s_right_speed (s_right_speed),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_left_drive  (m_left_drive),
        .m_right_drive (m_right_drive),
        .m_at_target   (m_at_target)
    );

    always #5 aclk = ~aclk;

    function automatic longint clip_drive(input longint v);
        if (v > DRIVE_MAX) return DRIVE_MAX;
        if (v < -DRIVE_MAX) return -DRIVE_MAX;
        return v;
    endfunction

    // feedforward plus speed feedback, truncated toward zero into drive units
    function automatic longint wheel_drive(input longint targ, input longint prev,
                                           input longint meas);
        longint sum;
        longint mag;
        sum = WHEEL_KV * targ + WHEEL_KA * (targ - prev) + WHEEL_KP * (targ - meas);
        mag = (sum < 0) ? -sum : sum;
        mag = mag >>> FRAC_BITS;
        return clip_drive((sum < 0) ? -mag : mag);
    endfunction

    // one control tick: turn speed, wheel targets, drives; queues the command
    task automatic step_controller(input logic signed [HEADING_W-1:0] hd,
                                   input logic signed [SPEED_W-1:0] ls,
                                   input logic signed [SPEED_W-1:0] rs);
        longint err, der, num, mag, spd, turn;
        longint tl, tr, dl, dr;
        drive_cmd_t cmd;
        err = longint'(cur_target) - longint'(hd);
        der = err - prev_error;
        num = TURN_P_GAIN * err + TURN_D_GAIN * der;
        mag = (num < 0) ? -num : num;
        spd = ((mag <<< FRAC_BITS) + TURN_SCALE / 2) / TURN_SCALE;
        // max clamp wins over min clamp, zero counts as positive
        if (spd > longint'(cur_max_speed)) spd = longint'(cur_max_speed);
        else if (spd < longint'(cur_min_speed)) spd = longint'(cur_min_speed);
        turn = (num < 0) ? -spd : spd;
        if (err > BAND_HUNDREDS || err < -BAND_HUNDREDS) begin
            tl = cur_sides[0] ? turn : 0;
            tr = cur_sides[1] ? -turn : 0;
            cmd.at_target = 1'b0;
        end else begin
            tl = 0;
            tr = 0;
            cmd.at_target = 1'b1;
        end
        // reverse swaps the measured wheels and the outputs
        if (cur_reverse) begin
            dr = wheel_drive(tl, prev_left_target, longint'(rs));
            dl = wheel_drive(tr, prev_right_target, longint'(ls));
        end else begin
            dl = wheel_drive(tl, prev_left_target, longint'(ls));
            dr = wheel_drive(tr, prev_right_target, longint'(rs));
        end
        if (cur_ovr_left != 0 || cur_ovr_right != 0) begin
            dl = clip_drive(longint'(cur_ovr_left));
            dr = clip_drive(longint'(cur_ovr_right));
        end
        prev_error        = err;
        prev_left_target  = tl;
        prev_right_target = tr;
        cmd.left_drive  = DRIVE_W'(dl);
        cmd.right_drive = DRIVE_W'(dr);
        pending_cmds.push_back(cmd);
    endtask

    // result side stalls at random
    always @(negedge aclk) begin
        m_ready <= steady_flow || ($urandom_range(99) >= 28);
    end

    // compare each result transaction with the oldest queued command
    always @(posedge aclk) begin : check_results
        drive_cmd_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_cmds.size() == 0) begin
                $error("result transaction with no command outstanding");
                fail_count++;
            end else begin
                want = pending_cmds.pop_front();
                if (m_left_drive !== want.left_drive) begin
                    $error("left_drive: expected %0d, actual %0d",
                           want.left_drive, m_left_drive);
                    fail_count++;
                end
                if (m_right_drive !== want.right_drive) begin
                    $error("right_drive: expected %0d, actual %0d",
                           want.right_drive, m_right_drive);
                    fail_count++;
                end
                if (m_at_target !== want.at_target) begin
                    $error("at_target: expected %0d, actual %0d",
                           want.at_target, m_at_target);
                    fail_count++;
                end
            end
        end
    end

    // one input transaction, entered and left at a falling edge
    task automatic send_sample(input logic signed [HEADING_W-1:0] hd,
                               input logic signed [SPEED_W-1:0] ls,
                               input logic signed [SPEED_W-1:0] rs);
        while (!steady_flow && $urandom_range(99) < 28) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_heading     <= hd;
        s_left_speed  <= ls;
        s_right_speed <= rs;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        step_controller(hd, ls, rs);
        @(negedge aclk);
    endtask

    // hold off the sender until every queued command has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        wait (pending_cmds.size() == 0);
        repeat (2) @(negedge aclk);
    endtask

    // register write, only with the block idle
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_TARGET_HEADING: cur_target    = data[HEADING_W-1:0];
            REG_MAX_TURN_SPEED: cur_max_speed = data[TSPEED_W-1:0];
            REG_MIN_TURN_SPEED: cur_min_speed = data[TSPEED_W-1:0];
            REG_TURN_SIDES:     cur_sides     = data[SIDES_W-1:0];
            REG_REVERSE_MODE:   cur_reverse   = data[0];
            REG_OVERRIDE_LEFT:  cur_ovr_left  = data[DRIVE_W-1:0];
            REG_OVERRIDE_RIGHT: cur_ovr_right = data[DRIVE_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // reset register values: zero turn speed, drives from speed feedback only
    task automatic test_reset_defaults();
        send_sample('0, SPEED_TOP, SPEED_BOTTOM);
        send_sample(HEADING_TOP, SPEED_BOTTOM, SPEED_TOP);
        send_sample(HEADING_BOTTOM, '0, '0);
        drain_results();
    endtask

    // edges of the one degree band and the working heading range
    task automatic test_band_edges();
        write_reg(REG_TARGET_HEADING, '0);
        write_reg(REG_MAX_TURN_SPEED, CFG_DATA_W'(1048576));
        write_reg(REG_MIN_TURN_SPEED, '0);
        send_sample(-100, 1000, -1000);
        send_sample(-101, '0, '0);
        send_sample(100, -5000, 5000);
        send_sample(101, '0, '0);
        send_sample(72000, 200000, -200000);
        send_sample(-72000, -200000, 200000);
        drain_results();
    endtask

    // min and max clamps, including a zero PD sum outside the band
    task automatic test_turn_clamps();
        write_reg(REG_MAX_TURN_SPEED, CFG_DATA_W'(300000));
        write_reg(REG_MIN_TURN_SPEED, CFG_DATA_W'(5000));
        send_sample(-121, '0, '0);
        send_sample(-110, '0, '0);     // 22*110 - 220*11 = 0, takes +min
        send_sample(110, '0, '0);
        send_sample(101, '0, '0);      // small negative sum, takes -min
        send_sample(72000, '0, '0);    // large sum, takes -max
        drain_results();
    endtask

    // every combination of wheel enables
    task automatic test_turn_sides();
        write_reg(REG_MAX_TURN_SPEED, CFG_DATA_W'(600000));
        write_reg(REG_MIN_TURN_SPEED, '0);
        for (int s = 0; s < 4; s++) begin
            write_reg(REG_TURN_SIDES, CFG_DATA_W'(s));
            send_sample((s % 2) ? 20000 : -20000, 30000, -30000);
        end
        write_reg(REG_TURN_SIDES, CFG_DATA_W'(3));
        drain_results();
    endtask

    // swapped measured wheels and outputs
    task automatic test_reverse();
        write_reg(REG_REVERSE_MODE, CFG_DATA_W'(1));
        send_sample(30000, 100000, -400000);
        send_sample(-30000, SPEED_BOTTOM, SPEED_TOP);
        write_reg(REG_REVERSE_MODE, '0);
    endtask

    // forced drives, the most negative override saturates
    task automatic test_override();
        write_reg(REG_OVERRIDE_LEFT, CFG_DATA_W'(8'h80));
        send_sample(5000, 0, 0);
        write_reg(REG_OVERRIDE_LEFT, '0);
        write_reg(REG_OVERRIDE_RIGHT, CFG_DATA_W'(127));
        send_sample(-5000, 0, 0);
        write_reg(REG_OVERRIDE_RIGHT, '0);
    endtask

    // random settings per phase, headings mostly closing in on the target
    task automatic test_random_tracking();
        int offset;
        logic signed [HEADING_W-1:0] hd;
        logic signed [SPEED_W-1:0]   ls, rs;
        for (int phase = 0; phase < 8; phase++) begin
            case ($urandom_range(3))
                0: write_reg(REG_TARGET_HEADING, CFG_DATA_W'(72000));
                1: write_reg(REG_TARGET_HEADING, CFG_DATA_W'(-72000));
                2: write_reg(REG_TARGET_HEADING, CFG_DATA_W'($urandom));
                default: write_reg(REG_TARGET_HEADING,
                                   CFG_DATA_W'(int'($urandom_range(144000)) - 72000));
            endcase
            case ($urandom_range(3))
                0: write_reg(REG_MAX_TURN_SPEED, '0);
                1: write_reg(REG_MAX_TURN_SPEED, CFG_DATA_W'(1048576));
                2: write_reg(REG_MAX_TURN_SPEED, '1);
                default: write_reg(REG_MAX_TURN_SPEED, CFG_DATA_W'($urandom_range(1048576)));
            endcase
            case ($urandom_range(3))
                0: write_reg(REG_MIN_TURN_SPEED, '0);
                1: write_reg(REG_MIN_TURN_SPEED, CFG_DATA_W'($urandom_range(20000)));
                2: write_reg(REG_MIN_TURN_SPEED, CFG_DATA_W'(1048576));
                default: write_reg(REG_MIN_TURN_SPEED, CFG_DATA_W'($urandom));
            endcase
            write_reg(REG_TURN_SIDES, CFG_DATA_W'($urandom));
            write_reg(REG_REVERSE_MODE, CFG_DATA_W'($urandom));
            // overrides mostly off, unused upper bits random
            if ($urandom_range(3) == 0) begin
                write_reg(REG_OVERRIDE_LEFT, CFG_DATA_W'($urandom));
                write_reg(REG_OVERRIDE_RIGHT, CFG_DATA_W'($urandom));
            end else begin
                write_reg(REG_OVERRIDE_LEFT, {13'($urandom), 8'h00});
                write_reg(REG_OVERRIDE_RIGHT, {13'($urandom), 8'h00});
            end
            steady_flow = (phase == 3);
            offset = 0;
            for (int n = 0; n < 66; n++) begin
                if (n % 12 == 0) begin
                    offset = $urandom_range(1) ? int'($urandom_range(144000)) - 72000
                                               : int'($urandom_range(600)) - 300;
                end
                if ($urandom_range(9) < 2) begin
                    // raw bit patterns across the full field widths
                    hd = HEADING_W'($urandom);
                    ls = SPEED_W'($urandom);
                    rs = SPEED_W'($urandom);
                end else begin
                    offset = offset - offset / 4 + int'($urandom_range(60)) - 30;
                    hd = HEADING_W'(int'(cur_target) - offset);
                    ls = SPEED_W'(int'($urandom_range(600000)) - 300000);
                    rs = SPEED_W'(int'($urandom_range(600000)) - 300000);
                end
                send_sample(hd, ls, rs);
                if (n == 33) drain_results();
            end
            drain_results();
            steady_flow = 1'b0;
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_heading     = '0;
        s_left_speed  = '0;
        s_right_speed = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_band_edges();
        test_turn_clamps();
        test_turn_sides();
        test_reverse();
        test_override();
        test_random_tracking();

        s_valid <= 1'b0;
        wait (pending_cmds.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_cmds.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
